/* rtl/core/rsh_pkg.sv */
// Shared types, constants and the CRC-16 helper for the serial slave frame handler.
package rsh_pkg;

    // CRC-16 with init 0xFFFF and polynomial 0x1021, MSB first, no final xor.
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam int MIN_FRAME_LEN = 8;
    localparam int SENSOR_COUNT  = 10;
    localparam int RESP_LEN      = 18;
    localparam int RESP_IDX_W    = $clog2(RESP_LEN);
    localparam int CMD_DEPTH     = 2;
    localparam int CFG_ADDR_W    = 5;

    localparam logic [7:0] SENSOR_COUNT_BYTE = 8'(SENSOR_COUNT);

    // Input item kinds and result types.
    localparam logic KIND_BYTE       = 1'b0;
    localparam logic KIND_ERROR      = 1'b1;
    localparam logic OUT_FRAME_BYTE  = 1'b0;
    localparam logic OUT_LIGHT_PULSE = 1'b1;

    // Configuration register indexes (byte address is four times the index).
    localparam logic [2:0] REG_HEADER_FIRST   = 3'd0;
    localparam logic [2:0] REG_HEADER_SECOND  = 3'd1;
    localparam logic [2:0] REG_TAIL_BYTE      = 3'd2;
    localparam logic [2:0] REG_OWN_ADDRESS    = 3'd3;
    localparam logic [2:0] REG_CODE_GET_PARAM = 3'd4;
    localparam logic [2:0] REG_CODE_RUN_LIGHT = 3'd5;

    // Positions inside the sensor-levels response frame.
    localparam logic [RESP_IDX_W-1:0] RESP_HDR_FIRST  = RESP_IDX_W'(0);
    localparam logic [RESP_IDX_W-1:0] RESP_HDR_SECOND = RESP_IDX_W'(1);
    localparam logic [RESP_IDX_W-1:0] RESP_ADDR       = RESP_IDX_W'(2);
    localparam logic [RESP_IDX_W-1:0] RESP_CODE       = RESP_IDX_W'(3);
    localparam logic [RESP_IDX_W-1:0] RESP_COUNT      = RESP_IDX_W'(4);
    localparam logic [RESP_IDX_W-1:0] RESP_SENSOR0    = RESP_IDX_W'(5);
    localparam logic [RESP_IDX_W-1:0] RESP_SENSOR_END = RESP_IDX_W'(5 + SENSOR_COUNT - 1);
    localparam logic [RESP_IDX_W-1:0] RESP_CRC_HI     = RESP_IDX_W'(5 + SENSOR_COUNT);
    localparam logic [RESP_IDX_W-1:0] RESP_CRC_LO     = RESP_IDX_W'(6 + SENSOR_COUNT);
    localparam logic [RESP_IDX_W-1:0] RESP_TAIL       = RESP_IDX_W'(RESP_LEN - 1);

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
        logic [9:0] sensor_levels;
    } t_in_item;

    typedef struct packed {
        logic       out_type;
        logic [7:0] tx_byte;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [7:0] header_first;
        logic [7:0] header_second;
        logic [7:0] tail_byte;
        logic [7:0] own_address;
        logic [7:0] code_get_param;
        logic [7:0] code_run_light;
    } t_cfg;

    typedef enum logic {
        CMD_GET,
        CMD_RUN
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [9:0] levels;
    } t_cmd;

    typedef enum logic {
        BK_IDLE,
        BK_RESP
    } t_back_state;

    // One byte of CRC-16, eight shift steps.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        int          j;
        c = crc_in ^ {data, 8'h00};
        for (j = 0; j < 8; j++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

/* rtl/core/rsh_front.sv */
// Receive side: tracks the frame byte by byte, checks it at the tail and queues a command.
module rsh_front #(
    parameter int BUFFER_BYTES = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rsh_pkg::t_cfg     i_cfg,
    input  rsh_pkg::t_in_item i_item,
    input  logic              i_accept,
    output logic              o_cmd_push,
    output rsh_pkg::t_cmd     o_cmd
);
    import rsh_pkg::*;

    localparam int CW = $clog2(BUFFER_BYTES);

    logic [CW-1:0] r_count, n_count;
    logic [15:0]   r_crc, n_crc;
    // Last three stored bytes, newest in r_win0.
    logic [7:0]    r_win0, r_win1, r_win2;
    logic [7:0]    r_hdr0, r_hdr1, r_hdr2, r_hdr3;

    logic          is_byte;
    logic          is_error;
    logic [15:0]   crc_after;
    logic          at_wrap;
    logic          at_end;
    logic          frame_ok;
    logic          is_get;
    logic          is_run;

    // The CRC lags three bytes behind, so at the tail it covers all but the last three.
    always_comb begin
        is_byte   = i_accept && (i_item.kind == KIND_BYTE);
        is_error  = i_accept && (i_item.kind == KIND_ERROR);
        crc_after = (r_count >= CW'(3)) ? crc16_byte(r_crc, r_win2) : r_crc;
        at_wrap   = (r_count == CW'(BUFFER_BYTES - 1));
        at_end    = !at_wrap && (r_count >= CW'(MIN_FRAME_LEN - 1))
                    && (i_item.rx_byte == i_cfg.tail_byte);
        frame_ok  = (r_hdr0 == i_cfg.header_first) && (r_hdr1 == i_cfg.header_second)
                    && ({r_win1, r_win0} == crc_after) && (r_hdr2 == i_cfg.own_address);
        is_get    = (r_hdr3 == i_cfg.code_get_param);
        is_run    = (r_hdr3 == i_cfg.code_run_light);

        o_cmd_push   = is_byte && at_end && frame_ok && (is_get || is_run);
        o_cmd.kind   = is_get ? CMD_GET : CMD_RUN;
        o_cmd.levels = i_item.sensor_levels;

        n_count = r_count;
        n_crc   = r_crc;
        if (is_error) begin
            n_count = '0;
            n_crc   = CRC_INIT;
        end else if (is_byte) begin
            if (at_wrap || at_end) begin
                n_count = '0;
                n_crc   = CRC_INIT;
            end else begin
                n_count = r_count + CW'(1);
                n_crc   = crc_after;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_crc   <= CRC_INIT;
        end else begin
            r_count <= n_count;
            r_crc   <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_byte) begin
            r_win0 <= i_item.rx_byte;
            r_win1 <= r_win0;
            r_win2 <= r_win1;
            case (r_count)
                CW'(0):  r_hdr0 <= i_item.rx_byte;
                CW'(1):  r_hdr1 <= i_item.rx_byte;
                CW'(2):  r_hdr2 <= i_item.rx_byte;
                CW'(3):  r_hdr3 <= i_item.rx_byte;
                default: ;
            endcase
        end
    end

endmodule

/* rtl/core/rsh_cmd_queue.sv */
// Short command queue between the receive side and the response side.
module rsh_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rsh_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_empty,
    input  logic          i_pop,
    output rsh_pkg::t_cmd o_cmd
);
    import rsh_pkg::*;

    localparam int PW = $clog2(CMD_DEPTH);
    localparam int NW = $clog2(CMD_DEPTH + 1);

    t_cmd          r_slot [CMD_DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [NW-1:0] r_fill, n_fill;
    logic          do_push;
    logic          do_pop;

    always_comb begin
        o_full   = (r_fill == NW'(CMD_DEPTH));
        o_empty  = (r_fill == '0);
        o_cmd    = r_slot[r_rd_ptr];
        do_push  = i_push && !o_full;
        do_pop   = i_pop && !o_empty;
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(CMD_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(CMD_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        n_fill = r_fill + NW'(do_push) - NW'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

/* rtl/core/rsh_back.sv */
// Response side: turns queued commands into result items through an output register.
module rsh_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rsh_pkg::t_cfg      i_cfg,
    input  logic               i_cmd_empty,
    input  rsh_pkg::t_cmd      i_cmd,
    output logic               o_cmd_pop,
    output logic               o_empty,
    input  logic               i_pop,
    output rsh_pkg::t_out_item o_item
);
    import rsh_pkg::*;

    t_back_state           r_state, n_state;
    logic [RESP_IDX_W-1:0] r_idx, n_idx;
    logic [15:0]           r_crc, n_crc;
    logic [9:0]            r_levels, n_levels;
    t_out_item             r_out, n_out;
    logic                  r_out_valid, n_out_valid;

    logic                  out_free;
    logic                  load_out;
    logic [RESP_IDX_W-1:0] lvl_sel;
    logic [9:0]            lvl_shift;
    logic [7:0]            resp_byte;

    // Byte of the response frame at the current position.
    always_comb begin
        lvl_sel   = r_idx - RESP_SENSOR0;
        lvl_shift = r_levels >> lvl_sel;
        case (r_idx) inside
            RESP_HDR_FIRST:                 resp_byte = i_cfg.header_first;
            RESP_HDR_SECOND:                resp_byte = i_cfg.header_second;
            RESP_ADDR:                      resp_byte = i_cfg.own_address;
            RESP_CODE:                      resp_byte = i_cfg.code_get_param;
            RESP_COUNT:                     resp_byte = SENSOR_COUNT_BYTE;
            [RESP_SENSOR0:RESP_SENSOR_END]: resp_byte = {7'b0, lvl_shift[0]};
            RESP_CRC_HI:                    resp_byte = r_crc[15:8];
            RESP_CRC_LO:                    resp_byte = r_crc[7:0];
            RESP_TAIL:                      resp_byte = i_cfg.tail_byte;
            default:                        resp_byte = 8'h00;
        endcase
    end

    assign out_free = !r_out_valid || i_pop;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_cmd_empty && out_free && (i_cmd.kind == CMD_GET)) begin
                    n_state = BK_RESP;
                end
            end
            BK_RESP: begin
                if (out_free && (r_idx == RESP_TAIL)) begin
                    n_state = BK_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        o_cmd_pop = 1'b0;
        load_out  = 1'b0;
        n_idx     = r_idx;
        n_crc     = r_crc;
        n_levels  = r_levels;
        n_out     = r_out;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_cmd_empty && out_free) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.kind == CMD_RUN) begin
                        load_out       = 1'b1;
                        n_out.out_type = OUT_LIGHT_PULSE;
                        n_out.tx_byte  = 8'h00;
                        n_out.last     = 1'b1;
                    end else begin
                        n_levels = i_cmd.levels;
                        n_idx    = '0;
                        n_crc    = CRC_INIT;
                    end
                end
            end
            BK_RESP: begin
                if (out_free) begin
                    load_out       = 1'b1;
                    n_out.out_type = OUT_FRAME_BYTE;
                    n_out.tx_byte  = resp_byte;
                    n_out.last     = (r_idx == RESP_TAIL);
                    if (r_idx < RESP_CRC_HI) begin
                        n_crc = crc16_byte(r_crc, resp_byte);
                    end
                    n_idx = r_idx + RESP_IDX_W'(1);
                end
            end
        endcase
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
        o_empty = !r_out_valid;
        o_item  = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_crc    <= n_crc;
        r_levels <= n_levels;
        r_out    <= n_out;
    end

    a_idx_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_RESP) |-> (r_idx <= RESP_TAIL))
        else $error("response index ran past the tail byte");

    a_pulse_shape : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.out_type == OUT_LIGHT_PULSE))
        |-> (r_out.last && (r_out.tx_byte == 8'h00)))
        else $error("light pulse item is not a single zero-byte last item");

    a_pop_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> ((r_state == BK_IDLE) && !i_cmd_empty))
        else $error("command taken while a response is in progress");

endmodule

/* rtl/core/rs485_slave_frame_handler_top.sv */
// Top level of the serial slave frame handler: configuration registers and the two halves.
// Throughput: one input item is accepted per cycle while the command queue has room.
// Path: a command pulse goes through the command queue and the output register to the result port;
// a sensor-levels response goes through the queue and the response state, then gives one item per
// cycle, 18 items in all, as fast as the consumer pops them; the response side sets that pace.
// Reset (synchronous, active low) clears the byte count, queue and output register and loads
// the configuration registers with their default values; the frame bytes themselves are not reset.
module rs485_slave_frame_handler_top #(
    parameter int BUFFER_BYTES = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Input item queue side.
    input  logic                                 push,
    output logic                                 full,
    input  rsh_pkg::t_in_item                    i_item,
    // Result queue side.
    output logic                                 empty,
    input  logic                                 pop,
    output rsh_pkg::t_out_item                   o_item,
    // Configuration port.
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [rsh_pkg::CFG_ADDR_W-1:0]       paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    import rsh_pkg::*;

    t_cfg       r_cfg, n_cfg;
    logic [2:0] reg_idx;
    logic       cfg_write;
    logic [7:0] rd_byte;

    logic       in_accept;
    logic       cmd_push;
    t_cmd       cmd_in;
    logic       cmd_full;
    logic       cmd_empty;
    logic       cmd_pop;
    t_cmd       cmd_head;

    // Registers sit on 32-bit word addresses; only the low byte of each is implemented.
    assign reg_idx   = paddr[4:2];
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_comb begin
        n_cfg   = r_cfg;
        rd_byte = 8'h00;
        unique case (reg_idx)
            REG_HEADER_FIRST: begin
                rd_byte = r_cfg.header_first;
                if (cfg_write) n_cfg.header_first = pwdata[7:0];
            end
            REG_HEADER_SECOND: begin
                rd_byte = r_cfg.header_second;
                if (cfg_write) n_cfg.header_second = pwdata[7:0];
            end
            REG_TAIL_BYTE: begin
                rd_byte = r_cfg.tail_byte;
                if (cfg_write) n_cfg.tail_byte = pwdata[7:0];
            end
            REG_OWN_ADDRESS: begin
                rd_byte = r_cfg.own_address;
                if (cfg_write) n_cfg.own_address = pwdata[7:0];
            end
            REG_CODE_GET_PARAM: begin
                rd_byte = r_cfg.code_get_param;
                if (cfg_write) n_cfg.code_get_param = pwdata[7:0];
            end
            REG_CODE_RUN_LIGHT: begin
                rd_byte = r_cfg.code_run_light;
                if (cfg_write) n_cfg.code_run_light = pwdata[7:0];
            end
            default: ;
        endcase
        prdata = {24'h000000, rd_byte};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_first   <= 8'hAA;
            r_cfg.header_second  <= 8'h55;
            r_cfg.tail_byte      <= 8'h0D;
            r_cfg.own_address    <= 8'h01;
            r_cfg.code_get_param <= 8'h01;
            r_cfg.code_run_light <= 8'h02;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // The receive side is held off only when the command queue has no room, so a
    // frame check at the tail byte always has a slot for its command.
    assign full      = cmd_full;
    assign in_accept = push && !cmd_full;

    rsh_front #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_item     (i_item),
        .i_accept   (in_accept),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in)
    );

    rsh_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (cmd_full),
        .o_empty (cmd_empty),
        .i_pop   (cmd_pop),
        .o_cmd   (cmd_head)
    );

    // The response side drains the queue; its output register keeps the result
    // port decoupled from the receive side.
    rsh_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (cmd_head),
        .o_cmd_pop   (cmd_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_item      (o_item)
    );

endmodule
